@@ hw/rtl/sdpmf_pkg.sv @@
package sdpmf_pkg;

  localparam int unsigned NUM_AXES_MAX = 3;
  localparam int unsigned AXIS_W       = 2;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 32;

  // Register reset values
  localparam logic [30:0] RST_STIFFNESS    = 31'd32768;
  localparam logic [30:0] RST_DAMPING      = 31'd2930;
  localparam logic [30:0] RST_INV_MASS     = 31'd65536000;
  localparam logic [31:0] RST_TIME_STEP    = 32'd4294967;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STIFFNESS = 2'd0,
    REG_DAMPING   = 2'd1,
    REG_INV_MASS  = 2'd2,
    REG_TIME_STEP = 2'd3
  } cfg_reg_t;

  // Per-axis sequence of the shared datapath
  typedef enum logic [2:0] {
    STEP_GAP     = 3'd0,
    STEP_SPRING  = 3'd1,
    STEP_INERT   = 3'd2,
    STEP_ACCEL   = 3'd3,
    STEP_VEL_MUL = 3'd4,
    STEP_VEL     = 3'd5,
    STEP_POS_MUL = 3'd6,
    STEP_POS     = 3'd7
  } step_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  typedef struct packed {
    logic               op;
    logic signed [31:0] proxy_x;
    logic signed [31:0] proxy_y;
    logic signed [31:0] proxy_z;
    logic signed [31:0] base_force_x;
    logic signed [31:0] base_force_y;
    logic signed [31:0] base_force_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic              load_in;
    logic              step_en;
    step_t             step;
    logic [AXIS_W-1:0] axis;
    logic              load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] val;
  } sat_t;

  function automatic sat_t sat34(input logic signed [33:0] v);
    sat_t r;
    r.hit = !((&v[33:31]) || !(|v[33:31]));
    if (!r.hit) begin
      r.val = v[31:0];
    end else if (v[33]) begin
      r.val = 32'sh8000_0000;
    end else begin
      r.val = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  function automatic sat_t sat65(input logic signed [64:0] v);
    sat_t r;
    r.hit = !((&v[64:31]) || !(|v[64:31]));
    if (!r.hit) begin
      r.val = v[31:0];
    end else if (v[64]) begin
      r.val = 32'sh8000_0000;
    end else begin
      r.val = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/sdpmf_ctrl.sv @@
module sdpmf_ctrl #(
  parameter int unsigned AXES = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_op,
  input  logic                  out_stall,
  output logic                  in_stall,
  output logic                  out_valid,
  output sdpmf_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  state_t                            state_r;
  sdpmf_pkg::step_t                  step_r;
  logic [sdpmf_pkg::AXIS_W-1:0]      axis_r;
  logic                              out_valid_r;
  logic                              last_axis;

  assign last_axis = (axis_r == sdpmf_pkg::AXIS_W'(AXES - 1));

  always_comb begin
    cmd.load_in  = (state_r == ST_IDLE) && in_valid;
    cmd.step_en  = (state_r == ST_RUN);
    cmd.step     = step_r;
    cmd.axis     = axis_r;
    cmd.load_out = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= sdpmf_pkg::STEP_GAP;
      axis_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid && (in_op == sdpmf_pkg::OP_TICK)) begin
            state_r <= ST_RUN;
            step_r  <= sdpmf_pkg::STEP_GAP;
            axis_r  <= '0;
          end
        end
        ST_RUN: begin
          if (step_r == sdpmf_pkg::STEP_POS) begin
            step_r <= sdpmf_pkg::STEP_GAP;
            if (last_axis) begin
              state_r <= ST_DONE;
            end else begin
              axis_r <= axis_r + 1'b1;
            end
          end else begin
            step_r <= sdpmf_pkg::step_t'(step_r + 3'd1);
          end
        end
        ST_DONE: begin
          if (cmd.load_out) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/sdpmf_dp.sv @@
module sdpmf_dp #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned AXES      = 3
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [sdpmf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sdpmf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  sdpmf_pkg::in_item_t                  in_data,
  input  sdpmf_pkg::ctrl_cmd_t                 cmd,
  output sdpmf_pkg::out_item_t                 out_data
);

  localparam int unsigned AW = (AXES > 1) ? $clog2(AXES) : 1;

  function automatic logic signed [31:0] proxy_of(input sdpmf_pkg::in_item_t it,
                                                  input logic [1:0] a);
    logic signed [31:0] r;
    unique case (a)
      2'd0:    r = it.proxy_x;
      2'd1:    r = it.proxy_y;
      default: r = it.proxy_z;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] base_of(input sdpmf_pkg::in_item_t it,
                                                 input logic [1:0] a);
    logic signed [31:0] r;
    unique case (a)
      2'd0:    r = it.base_force_x;
      2'd1:    r = it.base_force_y;
      default: r = it.base_force_z;
    endcase
    return r;
  endfunction

  // Configuration
  logic [30:0] stiff_r;
  logic [30:0] damp_r;
  logic [30:0] inv_mass_r;
  logic [31:0] time_step_r;

  // Mass state
  logic signed [31:0] pos_r [AXES];
  logic signed [31:0] vel_r [AXES];
  logic               flag_r;

  // Working registers
  sdpmf_pkg::in_item_t  in_r;
  sdpmf_pkg::out_item_t out_r;
  logic signed [64:0]   prod_r;
  logic signed [31:0]   gap_r;
  logic signed [31:0]   dmp_r;
  logic signed [31:0]   inert_r;
  logic signed [31:0]   force_r [AXES];

  logic [AW-1:0]      ax;
  logic signed [31:0] pos_cur, vel_cur, proxy_cur, base_cur;
  logic signed [64:0] prod_shf, prod_sh32;
  logic signed [32:0] hi32;
  sdpmf_pkg::sat_t    sh_f, gap_s, inert_s, force_s, vel_s, pos_s;
  logic signed [31:0] mul_a;
  logic signed [32:0] mul_b;
  logic               mul_en;
  logic               hit;
  logic signed [31:0] frc_all [sdpmf_pkg::NUM_AXES_MAX];

  assign ax        = cmd.axis[AW-1:0];
  assign pos_cur   = pos_r[ax];
  assign vel_cur   = vel_r[ax];
  assign proxy_cur = proxy_of(in_r, cmd.axis);
  assign base_cur  = base_of(in_r, cmd.axis);

  // floor division by 2^FRAC_BITS and by 2^32
  assign prod_shf  = prod_r >>> FRAC_BITS;
  assign prod_sh32 = prod_r >>> 32;
  assign hi32      = prod_sh32[32:0];

  assign sh_f    = sdpmf_pkg::sat65(prod_shf);
  assign gap_s   = sdpmf_pkg::sat34(34'(proxy_cur) - 34'(pos_cur));
  assign inert_s = sdpmf_pkg::sat34(34'(sh_f.val) - 34'(dmp_r));
  assign force_s = sdpmf_pkg::sat34(34'(base_cur) - 34'(inert_r));
  assign vel_s   = sdpmf_pkg::sat34(34'(vel_cur) + 34'(hi32));
  assign pos_s   = sdpmf_pkg::sat34(34'(pos_cur) + 34'(hi32));

  // Operand select for the shared multiplier, and clip flag per step
  always_comb begin
    mul_a  = vel_cur;
    mul_b  = {2'b00, damp_r};
    mul_en = 1'b0;
    hit    = 1'b0;
    unique case (cmd.step)
      sdpmf_pkg::STEP_GAP: begin
        mul_a  = vel_cur;
        mul_b  = {2'b00, damp_r};
        mul_en = 1'b1;
        hit    = gap_s.hit;
      end
      sdpmf_pkg::STEP_SPRING: begin
        mul_a  = gap_r;
        mul_b  = {2'b00, stiff_r};
        mul_en = 1'b1;
        hit    = sh_f.hit;
      end
      sdpmf_pkg::STEP_INERT: begin
        hit = sh_f.hit | inert_s.hit;
      end
      sdpmf_pkg::STEP_ACCEL: begin
        mul_a  = inert_r;
        mul_b  = {2'b00, inv_mass_r};
        mul_en = 1'b1;
        hit    = force_s.hit;
      end
      sdpmf_pkg::STEP_VEL_MUL: begin
        mul_a  = sh_f.val;
        mul_b  = {1'b0, time_step_r};
        mul_en = 1'b1;
        hit    = sh_f.hit;
      end
      sdpmf_pkg::STEP_VEL: begin
        hit = vel_s.hit;
      end
      sdpmf_pkg::STEP_POS_MUL: begin
        mul_a  = vel_cur;
        mul_b  = {1'b0, time_step_r};
        mul_en = 1'b1;
      end
      sdpmf_pkg::STEP_POS: begin
        hit = pos_s.hit;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stiff_r     <= sdpmf_pkg::RST_STIFFNESS;
      damp_r      <= sdpmf_pkg::RST_DAMPING;
      inv_mass_r  <= sdpmf_pkg::RST_INV_MASS;
      time_step_r <= sdpmf_pkg::RST_TIME_STEP;
    end else if (cfg_wr_en) begin
      unique case (sdpmf_pkg::cfg_reg_t'(cfg_index))
        sdpmf_pkg::REG_STIFFNESS: stiff_r     <= cfg_data[30:0];
        sdpmf_pkg::REG_DAMPING:   damp_r      <= cfg_data[30:0];
        sdpmf_pkg::REG_INV_MASS:  inv_mass_r  <= cfg_data[30:0];
        sdpmf_pkg::REG_TIME_STEP: time_step_r <= cfg_data;
        default:                  stiff_r     <= stiff_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < AXES; a++) begin
        pos_r[a] <= '0;
        vel_r[a] <= '0;
      end
      flag_r <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        if (in_data.op == sdpmf_pkg::OP_TICK) begin
          flag_r <= 1'b0;
        end else begin
          for (int a = 0; a < AXES; a++) begin
            pos_r[a] <= proxy_of(in_data, 2'(a));
            vel_r[a] <= '0;
          end
        end
      end
      if (cmd.step_en) begin
        flag_r <= flag_r | hit;
        if (cmd.step == sdpmf_pkg::STEP_VEL) begin
          vel_r[ax] <= vel_s.val;
        end
        if (cmd.step == sdpmf_pkg::STEP_POS) begin
          pos_r[ax] <= pos_s.val;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
    if (cmd.step_en && mul_en) begin
      prod_r <= 65'(mul_a) * 65'(mul_b);
    end
    if (cmd.step_en) begin
      if (cmd.step == sdpmf_pkg::STEP_GAP) begin
        gap_r <= gap_s.val;
      end
      if (cmd.step == sdpmf_pkg::STEP_SPRING) begin
        dmp_r <= sh_f.val;
      end
      if (cmd.step == sdpmf_pkg::STEP_INERT) begin
        inert_r <= inert_s.val;
      end
      if (cmd.step == sdpmf_pkg::STEP_ACCEL) begin
        force_r[ax] <= force_s.val;
      end
    end
    if (cmd.load_out) begin
      out_r.force_x   <= frc_all[0];
      out_r.force_y   <= frc_all[1];
      out_r.force_z   <= frc_all[2];
      out_r.saturated <= flag_r;
    end
  end

  // Axes beyond AXES pass the base force through
  for (genvar a = 0; a < sdpmf_pkg::NUM_AXES_MAX; a++) begin : g_frc
    if (a < AXES) begin : g_act
      assign frc_all[a] = force_r[a];
    end else begin : g_pass
      assign frc_all[a] = base_of(in_r, 2'(a));
    end
  end

  assign out_data = out_r;

endmodule

@@ hw/rtl/spring_damper_point_mass_force.sv @@
// Spring-damper point mass force, semi-implicit Euler, Q16.16 fixed point.
//
// Input channel (in_valid / in_stall / in_data): one item per servo tick.
//   op = start : the mass is placed at the proxy and its velocity cleared.
//                No result item. The block is ready again the next cycle.
//   op = tick  : force = base - (k * gap - c * vel); velocity, then position,
//                are integrated with inverse mass and time step. One result.
// Output channel (out_valid / out_stall / out_data): force on each axis and a
//   sticky flag that is set when any clip to 32 bits happened in the tick.
// Config port (cfg_wr_en / cfg_index / cfg_data): stiffness, damping,
//   inverse mass, time step. Write only while the block is idle.
// Datapath: one shared 32x33 multiplier with a registered product; each axis
//   takes 8 steps, and a tick holds in_stall until its result is moved into
//   the output register, which is also when out_valid rises.
// The result sits in an output register: a stalled receiver does not stop
//   the next item from being taken; only a finished tick that finds the
//   output register still full waits for it to drain.
// Reset (rst_n, synchronous): registers to defaults, mass state to zero.
module spring_damper_point_mass_force #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned AXES      = 3
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [sdpmf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sdpmf_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  sdpmf_pkg::in_item_t                in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output sdpmf_pkg::out_item_t               out_data
);

  sdpmf_pkg::ctrl_cmd_t cmd;

  // sequencer: accept, per-axis step walk, output hand-off
  sdpmf_ctrl #(
    .AXES (AXES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.op),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // config, mass state, shared multiplier, clip logic, output register
  sdpmf_dp #(
    .FRAC_BITS (FRAC_BITS),
    .AXES      (AXES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_data  (out_data)
  );

endmodule

@@ hw/rtl/sdpmf_chk.sv @@
module sdpmf_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input sdpmf_pkg::in_item_t                in_data,
  input logic                               out_valid,
  input logic                               out_stall,
  input sdpmf_pkg::out_item_t               out_data
);

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // no result survives reset
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  // a held result does not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a taken tick makes the block stall its input
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_data.op == sdpmf_pkg::OP_TICK) |=> in_stall)
    else $error("input taken during a tick");

  // a start item produces no result
  a_start_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_data.op == sdpmf_pkg::OP_START) && !out_valid |=> !out_valid)
    else $error("result after start item");

  // results only come out of a running tick
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a tick");

endmodule

bind spring_damper_point_mass_force sdpmf_chk u_chk (.*);

@@ verif/tb.sv @@
module tb;

  localparam int     FRAC_BITS     = 16;
  localparam int     AXES          = 3;
  localparam longint MAX32         = 64'sd2147483647;
  localparam longint MIN32         = -64'sd2147483648;
  // one tick holds the block for 8 steps per axis plus the load
  localparam int     DRAIN_CYCLES  = 8 * AXES + 40;
  localparam int     HOLD_CYCLES   = 400;
  localparam int     SEGMENT_ITEMS = 82;
  localparam logic [31:0] MAXV     = 32'h7FFF_FFFF;
  localparam logic [31:0] MINV     = 32'h8000_0000;
  localparam logic [31:0] ONE      = 32'h0001_0000;

  // Bit-true model of the mass state plus the queue of forces still owed by the block.
  class force_scoreboard;
    longint                stiffness, damping, inv_mass, time_step;
    longint                position [AXES];
    longint                velocity [AXES];
    bit                    clipped;
    sdpmf_pkg::out_item_t  expected_forces [$];
    int                    errors;
    int                    ticks_checked;
    int                    saturated_ticks;

    function new();
      stiffness = longint'(sdpmf_pkg::RST_STIFFNESS);
      damping   = longint'(sdpmf_pkg::RST_DAMPING);
      inv_mass  = longint'(sdpmf_pkg::RST_INV_MASS);
      time_step = longint'(sdpmf_pkg::RST_TIME_STEP);
      foreach (position[a]) begin
        position[a] = 0;
        velocity[a] = 0;
      end
    endfunction

    // Bits above each register's width are dropped, as the block does.
    function void write_reg(sdpmf_pkg::cfg_reg_t idx, logic [31:0] data);
      case (idx)
        sdpmf_pkg::REG_STIFFNESS: stiffness = longint'(data[30:0]);
        sdpmf_pkg::REG_DAMPING:   damping   = longint'(data[30:0]);
        sdpmf_pkg::REG_INV_MASS:  inv_mass  = longint'(data[30:0]);
        sdpmf_pkg::REG_TIME_STEP: time_step = longint'(data[31:0]);
        default: ;
      endcase
    endfunction

    function longint sat32(longint v);
      if (v > MAX32) begin
        clipped = 1'b1;
        return MAX32;
      end
      if (v < MIN32) begin
        clipped = 1'b1;
        return MIN32;
      end
      return v;
    endfunction

    // Start moves the mass onto the proxy; a tick owes one force item.
    // Shifts of signed longints round toward minus infinity.
    function void predict_force(sdpmf_pkg::in_item_t it);
      longint                proxy [AXES];
      longint                base [AXES];
      longint                force_v [AXES];
      longint                gap, spring, damp, inert, accel, vel, pos;
      sdpmf_pkg::out_item_t  f;
      proxy[0] = $signed(it.proxy_x);
      proxy[1] = $signed(it.proxy_y);
      proxy[2] = $signed(it.proxy_z);
      base[0]  = $signed(it.base_force_x);
      base[1]  = $signed(it.base_force_y);
      base[2]  = $signed(it.base_force_z);
      if (it.op == sdpmf_pkg::OP_START) begin
        foreach (position[a]) begin
          position[a] = proxy[a];
          velocity[a] = 0;
        end
        return;
      end
      clipped = 1'b0;
      for (int a = 0; a < AXES; a++) begin
        gap    = sat32(proxy[a] - position[a]);
        spring = sat32((stiffness * gap) >>> FRAC_BITS);
        damp   = sat32((damping * velocity[a]) >>> FRAC_BITS);
        inert  = sat32(spring - damp);
        accel  = sat32((inert * inv_mass) >>> FRAC_BITS);
        vel    = sat32(velocity[a] + ((accel * time_step) >>> 32));
        pos    = sat32(position[a] + ((vel * time_step) >>> 32));
        velocity[a] = vel;
        position[a] = pos;
        force_v[a]  = sat32(base[a] - inert);
      end
      f.force_x   = 32'(force_v[0]);
      f.force_y   = 32'(force_v[1]);
      f.force_z   = 32'(force_v[2]);
      f.saturated = clipped;
      expected_forces.push_back(f);
    endfunction

    // Output is capped so a broken block cannot flood the log; the count stays exact.
    task report(string what);
      errors++;
      if (errors <= 50) begin
        $display("MISMATCH at %0t: %s", $realtime, what);
      end
    endtask

    task check_force(sdpmf_pkg::out_item_t got);
      sdpmf_pkg::out_item_t want;
      if (expected_forces.size() == 0) begin
        report($sformatf("force item with none expected: %h", got));
        return;
      end
      want = expected_forces.pop_front();
      ticks_checked++;
      if (want.saturated) begin
        saturated_ticks++;
      end
      if (got.force_x !== want.force_x) begin
        report($sformatf("force_x got %h want %h", got.force_x, want.force_x));
      end
      if (got.force_y !== want.force_y) begin
        report($sformatf("force_y got %h want %h", got.force_y, want.force_y));
      end
      if (got.force_z !== want.force_z) begin
        report($sformatf("force_z got %h want %h", got.force_z, want.force_z));
      end
      if (got.saturated !== want.saturated) begin
        report($sformatf("saturated got %b want %b", got.saturated, want.saturated));
      end
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // Block hookup; every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  sdpmf_pkg::cfg_reg_t   cfg_index = sdpmf_pkg::REG_STIFFNESS;
  logic [31:0]           cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  sdpmf_pkg::in_item_t   in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  sdpmf_pkg::out_item_t  out_data;

  // Receiver hold-off request, set by its own counting process.
  logic       out_hold  = 1'b0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         items_sent    = 0;
  int         config_sets   = 0;

  force_scoreboard sb = new();

  spring_damper_point_mass_force i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Accepted items are sampled at the edge that accepts them; the drivers only
  // move signals by NBA, so these reads see the pre-edge values.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      sb.predict_force(in_data);
    end
    if (rst_n && out_valid && !out_stall) begin
      sb.check_force(out_data);
    end
  end

  // Receiver: random stalls at the current rate, or solid during a hold-off.
  always @(posedge clk) begin
    out_stall <= out_hold || ($urandom_range(99) < recv_idle_pct);
  end

  // Long receiver hold-off; the output register fills, then the block stalls
  // its input while the sender keeps offering items.
  task automatic hold_receiver(int cycles);
    out_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    out_hold <= 1'b0;
  endtask

  // Offer one item and return at the edge that takes it. A sender gap,
  // when drawn, is random up to longer than a tick so it lands on every phase of a tick.
  task automatic send_item(sdpmf_pkg::in_item_t it);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 30);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Wait until every owed force came back, then let a start item finish too.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_forces.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(sdpmf_pkg::cfg_reg_t idx, logic [31:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  // Only called while the block is idle.
  task automatic set_config(logic [31:0] stiff, damp, inv, ts);
    write_reg(sdpmf_pkg::REG_STIFFNESS, stiff);
    write_reg(sdpmf_pkg::REG_DAMPING, damp);
    write_reg(sdpmf_pkg::REG_INV_MASS, inv);
    write_reg(sdpmf_pkg::REG_TIME_STEP, ts);
    cfg_wr_en <= 1'b0;
    config_sets++;
  endtask

  function automatic sdpmf_pkg::in_item_t mk(sdpmf_pkg::op_t op,
                                             logic [31:0] px, py, pz, bx, by, bz);
    sdpmf_pkg::in_item_t it;
    it.op           = op;
    it.proxy_x      = px;
    it.proxy_y      = py;
    it.proxy_z      = pz;
    it.base_force_x = bx;
    it.base_force_y = by;
    it.base_force_z = bz;
    return it;
  endfunction

  // Uniform in [-span, span], two's complement.
  function automatic logic [31:0] srand(int unsigned span);
    return $urandom_range(2 * span) - span;
  endfunction

  // Directed: field extremes, both ops, gap and force clipping, zero inverse
  // mass (mass frozen), zero time step (state frozen), register bits above width.
  task automatic run_directed();
    // reset defaults, mass at origin
    send_item(mk(sdpmf_pkg::OP_TICK, 0, 0, 0, 0, 0, 0));
    send_item(mk(sdpmf_pkg::OP_TICK, MAXV, MINV, 0, 0, 0, 0));
    send_item(mk(sdpmf_pkg::OP_TICK, 1, -1, ONE, MAXV, MINV, 12345));
    send_item(mk(sdpmf_pkg::OP_START, MINV, MAXV, 0, MAXV, MINV, 1));
    send_item(mk(sdpmf_pkg::OP_TICK, MAXV, MINV, 0, 0, 0, 0));
    send_item(mk(sdpmf_pkg::OP_TICK, MINV, MAXV, 100, MINV, MAXV, -1));
    send_item(mk(sdpmf_pkg::OP_START, 0, 0, 0, 0, 0, 0));
    repeat (3) send_item(mk(sdpmf_pkg::OP_TICK, ONE, -ONE, ONE / 2, 0, 0, 0));
    settle();
    // all-ones data: every register at its maximum, top bits dropped
    set_config('1, '1, '1, '1);
    send_item(mk(sdpmf_pkg::OP_START, 0, 0, 0, 0, 0, 0));
    send_item(mk(sdpmf_pkg::OP_TICK, ONE, -ONE, 1, 0, 0, 0));
    repeat (2) send_item(mk(sdpmf_pkg::OP_TICK, MAXV, MINV, -1, MAXV, MINV, 0));
    settle();
    // zero inverse mass: no acceleration
    set_config(sdpmf_pkg::RST_STIFFNESS, sdpmf_pkg::RST_DAMPING, 0,
               sdpmf_pkg::RST_TIME_STEP);
    send_item(mk(sdpmf_pkg::OP_START, 1000, 2000, 3000, 0, 0, 0));
    repeat (2) send_item(mk(sdpmf_pkg::OP_TICK, 70000, -70000, 0, 5, 6, 7));
    settle();
    // zero spring, damper and time step
    set_config(0, 0, sdpmf_pkg::RST_INV_MASS, 0);
    send_item(mk(sdpmf_pkg::OP_TICK, MAXV, MINV, 7, 1, 2, 3));
    settle();
    // longest time step with the smallest legal inverse mass
    set_config(sdpmf_pkg::RST_STIFFNESS, sdpmf_pkg::RST_DAMPING, 1, MAXV | MINV);
    send_item(mk(sdpmf_pkg::OP_START, 0, 0, 0, 0, 0, 0));
    repeat (3) send_item(mk(sdpmf_pkg::OP_TICK, 10 * ONE, -10 * ONE, 3, 0, 0, 0));
  endtask

  // One register setting per segment: defaults, a plausible random set,
  // raw random words, then one extreme corner per idle pattern.
  task automatic apply_setting(int k, int mode);
    case (k)
      0: set_config(sdpmf_pkg::RST_STIFFNESS, sdpmf_pkg::RST_DAMPING,
                    sdpmf_pkg::RST_INV_MASS, sdpmf_pkg::RST_TIME_STEP);
      1: set_config($urandom_range(0, 1 << 22), $urandom_range(0, 1 << 16),
                    $urandom_range(1, 1 << 27), $urandom_range(0, 1 << 24));
      2: set_config($urandom(), $urandom(), $urandom(), $urandom());
      default: begin
        if (mode == 0) begin
          set_config(MAXV, MAXV, MAXV, '1);
        end else if (mode == 1) begin
          set_config(0, 0, 1, 0);
        end else begin
          set_config(MAXV, 0, 1, '1);
        end
      end
    endcase
  endtask

  // Mostly start-then-ticks runs with the proxy wandering near the mass;
  // the rest is noise: random ops and full-range fields, ticks with no start.
  task automatic run_segment(int n);
    logic [31:0] p [AXES];
    logic [31:0] b [AXES];
    int          sent;
    int          run_len;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 15) begin
        send_item(mk(sdpmf_pkg::op_t'($urandom_range(1)),
                     $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom(), $urandom()));
        sent++;
      end else begin
        foreach (p[a]) begin
          p[a] = ($urandom_range(9) == 0) ? $urandom() : srand(1 << 22);
        end
        send_item(mk(sdpmf_pkg::OP_START, p[0], p[1], p[2],
                     $urandom(), $urandom(), $urandom()));
        sent++;
        run_len = $urandom_range(1, 24);
        repeat (run_len) begin
          foreach (p[a]) begin
            p[a] = p[a] + srand(1 << 15);
            b[a] = ($urandom_range(7) == 0) ? $urandom() : srand(1 << 18);
          end
          send_item(mk(sdpmf_pkg::OP_TICK, p[0], p[1], p[2], b[0], b[1], b[2]));
          sent++;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed items, then three idle patterns with four
  // register settings each.
  // ---------------------------------------------------------------------------
  initial begin
    int mode;
    int k;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 31;
    recv_idle_pct = 69;
    run_directed();
    for (mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 31 : (mode == 1) ? 69 : 0;
      recv_idle_pct = (mode == 0) ? 69 : (mode == 1) ? 31 : 0;
      for (k = 0; k < 4; k++) begin
        settle();
        apply_setting(k, mode);
        if (mode == 2 && k == 0) begin
          fork
            hold_receiver(HOLD_CYCLES);
          join_none
        end
        run_segment(SEGMENT_ITEMS);
      end
    end
    settle();
    $display("Covered %0d items, %0d force ticks checked (%0d with clipping), %0d settings.",
             items_sent, sb.ticks_checked, sb.saturated_ticks, config_sets);
    $display("Idle mixes 31/69, 69/31 and none, plus one %0d-cycle receiver hold-off.",
             HOLD_CYCLES);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("TEST FAILED");
    end
    $finish;
  end

  // Far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Timeout with %0d force items still owed", sb.expected_forces.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
